[hw/rtl/ulbp_pkg.sv]
package ulbp_pkg;

  localparam int PIXEL_W = 8;
  localparam int LABEL_W = 6;
  localparam int SIZE_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CODE_W = 8;
  localparam int CODES = 256;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;
  localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd3;

  typedef logic [LABEL_W-1:0] label_table_t [CODES];

  // Number of 0/1 changes going once around the circular 8-bit code.
  function automatic int unsigned code_transitions(logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] rot;
    logic [CODE_W-1:0] diff;
    int unsigned n;
    rot = {code[CODE_W-2:0], code[CODE_W-1]};
    diff = code ^ rot;
    n = 0;
    for (int i = 0; i < CODE_W; i++) begin
      n += int'(diff[i]);
    end
    return n;
  endfunction

  // Uniform codes get labels 1..58 in ascending code order; the rest get 0.
  function automatic label_table_t build_label_table();
    label_table_t tbl;
    int unsigned n;
    n = 0;
    for (int c = 0; c < CODES; c++) begin
      if (code_transitions(CODE_W'(c)) <= 2) begin
        n++;
        tbl[c] = LABEL_W'(n);
      end else begin
        tbl[c] = '0;
      end
    end
    return tbl;
  endfunction

  localparam label_table_t LABEL_TABLE = build_label_table();

endpackage

[hw/rtl/ulbp_line_mem.sv]
module ulbp_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/uniform_lbp_operator.sv]
// A result passes the s1, s2 and output registers after the pixel at its window's bottom-right
// corner is accepted. Throughput: one pixel per cycle unless out_ready stalls, set by the
// single line memory, read at a pixel's acceptance and written at another column as it leaves s1.
// Reset clears all valid flags, the row and column counts and the window, and sets the frame
// size to 640 by 480. The line memory is not cleared; its first two rows of a frame are
// written before any result depends on them.
module uniform_lbp_operator import ulbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_W-1:0]     pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LABEL_W-1:0]     label,
  output logic                   row_end,
  output logic                   frame_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MW = 2 * PIXEL_W;

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic in_fire;
  logic cfg_fire;

  logic s1_valid;
  logic s1_result;
  logic s1_row_end;
  logic s1_frame_end;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [CW-1:0] s1_col;
  logic s1_go;

  logic s2_valid;
  logic s2_row_end;
  logic s2_frame_end;
  logic [CODE_W-1:0] s2_code;
  logic s2_go;
  logic s2_free;
  logic out_free;

  logic [MW-1:0] rd_data;
  logic [PIXEL_W-1:0] top;
  logic [PIXEL_W-1:0] mid;
  logic [PIXEL_W-1:0] ctr;
  logic [CODE_W-1:0] code;
  logic [PIXEL_W-1:0] window [6];

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire = in_valid && in_ready;

  assign out_free = !out_valid || out_ready;
  assign s2_go = s2_valid && out_free;
  assign s2_free = !s2_valid || s2_go;
  assign s1_go = s1_valid && (!s1_result || s2_free);
  assign in_ready = !s1_valid || s1_go;

  always_comb begin
    if (image_width < MIN_SIZE) begin
      width_last = CW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_last = CW'(MAX_WIDTH - 1);
    end else begin
      width_last = CW'(image_width - 11'd1);
    end
  end

  always_comb begin
    if (image_height < MIN_SIZE) begin
      height_last = RW'(2);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_last = RW'(MAX_HEIGHT - 1);
    end else begin
      height_last = RW'(image_height - 11'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_fire && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col == width_last) begin
        col <= '0;
        row <= (row == height_last) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  ulbp_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW(CW),
    .DW(MW)
  ) u_line_mem (
    .clk(clk),
    .rd_en(in_fire),
    .rd_addr(col),
    .rd_data(rd_data),
    .wr_en(s1_go),
    .wr_addr(s1_col),
    .wr_data({mid, s1_pixel})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel <= pixel;
      s1_col <= col;
      s1_result <= (row >= RW'(2)) && (col >= CW'(2));
      s1_row_end <= (col == width_last);
      s1_frame_end <= (col == width_last) && (row == height_last);
    end
  end

  assign top = rd_data[MW-1:PIXEL_W];
  assign mid = rd_data[PIXEL_W-1:0];
  assign ctr = window[1];

  always_comb begin
    code = {window[3] >= ctr, window[0] >= ctr, top >= ctr, mid >= ctr,
            s1_pixel >= ctr, window[2] >= ctr, window[5] >= ctr, window[4] >= ctr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else if (s1_go) begin
      window[3] <= window[0];
      window[4] <= window[1];
      window[5] <= window[2];
      window[0] <= top;
      window[1] <= mid;
      window[2] <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_go && s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_go && s1_result) begin
      s2_code <= code;
      s2_row_end <= s1_row_end;
      s2_frame_end <= s1_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      label <= LABEL_TABLE[s2_code];
      row_end <= s2_row_end;
      frame_end <= s2_frame_end;
    end
  end

endmodule

[hw/rtl/ulbp_checker.sv]
module ulbp_checker import ulbp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LABEL_W-1:0] label,
  input logic               row_end,
  input logic               frame_end
);

  localparam logic [LABEL_W-1:0] LABEL_MAX = 6'd58;

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output item valid right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output item dropped while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(label) && $stable(row_end) && $stable(frame_end))
    else $error("Output item changed while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("Frame end without row end.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> label <= LABEL_MAX)
    else $error("Label out of range.");

endmodule

bind uniform_lbp_operator ulbp_checker u_ulbp_checker (.*);
